// File: hdl/ptw_pkg.sv
// Shared types and codes for the page table walker: request and response
// transactions, request and status codes, memory command group.
// No dependencies.
`default_nettype none

package ptw_pkg;

  localparam int TBASE_W = 18;

  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_XLATE = 3'd1,
    REQ_SET   = 3'd2,
    REQ_CLR   = 3'd3,
    REQ_MAP   = 3'd4,
    REQ_UNMAP = 3'd5
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FAULT  = 2'd1,
    ST_NOTSEC = 2'd2,
    ST_MAPPED = 2'd3
  } status_t;

  // Descriptor type codes, bits 1:0
  localparam logic [1:0] DT_FAULT = 2'd0;
  localparam logic [1:0] DT_COARSE = 2'd1;
  localparam logic [1:0] DT_SECTION = 2'd2;

  localparam logic [1:0] PT_LARGE = 2'd1;
  localparam logic [1:0] PT_SMALL = 2'd2;
  localparam logic [1:0] PT_TINY = 2'd3;

  // Fixed fields of a new section descriptor: AP full, domain bit, type
  localparam logic [31:0] SECTION_ATTR = 32'h0000_0c32;
  // All access permission bits of a small page
  localparam logic [31:0] SMALL_AP_ALL = 32'h0000_0ff0;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] vaddr;
    logic [15:0] word_index;
    logic [31:0] word_data;
    logic [31:0] paddr;
    logic        cache_bit;
    logic        buffer_bit;
  } req_t;

  typedef struct packed {
    logic [31:0] xlate_addr;
    logic [1:0]  status;
    logic [31:0] written_desc;
  } rsp_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_cmd_t;

endpackage

`default_nettype wire

// File: hdl/page_table_walk_and_update.sv
// Top level of the two-level page table walker: sequencer plus table memory.
// Depends on ptw_pkg, ptw_mem and ptw_ctrl.
`default_nettype none

// The block walks and edits two-level page tables kept in an internal word
// memory of MEM_WORDS entries (a power of two); table word addresses wrap
// modulo that size. Every request transaction yields exactly one response
// transaction. Tables must be loaded with load requests before any other
// request reads them; the memory has no reset. Requests are handled one at a
// time by a sequencer in front of a single-port memory with a registered
// read. A load writes one word; walks and edits read the first-level
// descriptor, page walks and page attribute changes then the second-level
// one, and an edit that succeeds writes its descriptor back. The response
// sits in an output register, so the next request is taken while it waits;
// a stalled response holds the next one back in the sequencer. The user must
// write table_base through cfg_write/cfg_data only while the block is idle;
// the block does not enforce it. table_base takes effect at the next request.
module page_table_walk_and_update
  import ptw_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire req_t               in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rsp_t                    out_data,
  input  wire logic               cfg_write,
  input  wire logic [TBASE_W-1:0] cfg_data
);

  localparam int AW = $clog2(MEM_WORDS);

  mem_cmd_t      mem_cmd;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  // Sequencer: owns the memory port, so accesses never overlap and
  // read-modify-write needs no forwarding.
  ptw_ctrl #(.AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // Table storage
  ptw_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// File: hdl/ptw_mem.sv
// Single-port table memory with a registered read, one access per cycle.
// Depends on ptw_pkg for the memory command group.
`default_nettype none

module ptw_mem
  import ptw_pkg::*;
#(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire mem_cmd_t      cmd,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic [31:0]        rdata
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/ptw_ctrl.sv
// Walk sequencer: latches a request, reads and writes back descriptors
// through the table memory port, holds the table base and the result register.
// Depends on ptw_pkg.
`default_nettype none

module ptw_ctrl
  import ptw_pkg::*;
#(
  parameter int AW = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire req_t               in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rsp_t                    out_data,
  input  wire logic               cfg_write,
  input  wire logic [TBASE_W-1:0] cfg_data,
  output mem_cmd_t                mem_cmd,
  output logic [AW-1:0]           mem_addr,
  output logic [31:0]             mem_wdata,
  input  wire logic [31:0]        mem_rdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_L1   = 5'b00010,
    S_W1   = 5'b00100,
    S_W2   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state, state_next;
  req_t                req;
  rsp_t                res, res_next;
  logic [AW-1:0]       slot, slot_next;
  logic [TBASE_W-1:0]  table_base;

  logic [29:0] l1_word, l2_word;
  logic [31:0] idx_word;
  logic [31:0] bits;
  logic [31:0] upd;
  logic        is_set;
  logic        in_take, out_take;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign l1_word  = {table_base, req.vaddr[31:20]};
  assign l2_word  = (mem_rdata[1:0] == DT_COARSE) ? {mem_rdata[31:10], req.vaddr[19:12]}
                                                  : {mem_rdata[31:12], req.vaddr[19:10]};
  assign idx_word = {16'b0, req.word_index};
  assign bits     = {28'b0, req.cache_bit, req.buffer_bit, 2'b00};
  assign is_set   = (req.req_type == REQ_SET);
  assign upd      = is_set ? (mem_rdata | bits) : (mem_rdata & ~bits);

  always_comb begin
    state_next = state;
    res_next   = res;
    slot_next  = slot;
    mem_cmd    = '0;
    mem_addr   = l1_word[AW-1:0];
    mem_wdata  = '0;
    unique case (state)
      S_IDLE: begin
        res_next = '0;
        if (in_take) begin
          state_next = S_L1;
        end
      end
      S_L1: begin
        priority if (req.req_type == REQ_LOAD) begin
          mem_cmd   = '{en: 1'b1, we: 1'b1};
          mem_addr  = idx_word[AW-1:0];
          mem_wdata = req.word_data;
          res_next.written_desc = req.word_data;
          state_next = S_DONE;
        end else if (req.req_type <= REQ_UNMAP) begin
          mem_cmd    = '{en: 1'b1, we: 1'b0};
          state_next = S_W1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_W1: begin
        // mem_rdata holds the first-level descriptor
        state_next = S_DONE;
        unique case (req.req_type)
          REQ_XLATE: begin
            if (mem_rdata[1:0] == DT_SECTION) begin
              res_next.xlate_addr = {mem_rdata[31:20], req.vaddr[19:0]};
            end else if (mem_rdata[1:0] == DT_FAULT) begin
              res_next.status = ST_FAULT;
            end else begin
              mem_cmd    = '{en: 1'b1, we: 1'b0};
              mem_addr   = l2_word[AW-1:0];
              state_next = S_W2;
            end
          end
          REQ_SET, REQ_CLR: begin
            if (mem_rdata[1:0] == DT_FAULT) begin
              res_next.status = ST_FAULT;
            end else if (mem_rdata[1:0] == DT_SECTION) begin
              mem_cmd   = '{en: 1'b1, we: 1'b1};
              mem_wdata = upd;
              res_next.written_desc = upd;
            end else begin
              mem_cmd    = '{en: 1'b1, we: 1'b0};
              mem_addr   = l2_word[AW-1:0];
              slot_next  = l2_word[AW-1:0];
              state_next = S_W2;
            end
          end
          REQ_MAP: begin
            if (mem_rdata[1:0] != DT_FAULT) begin
              res_next.status = ST_MAPPED;
            end else begin
              mem_cmd   = '{en: 1'b1, we: 1'b1};
              mem_wdata = {req.paddr[31:20], 20'b0} | SECTION_ATTR | bits;
              res_next.written_desc = mem_wdata;
            end
          end
          REQ_UNMAP: begin
            if (mem_rdata[1:0] != DT_SECTION) begin
              res_next.status = ST_NOTSEC;
            end else begin
              mem_cmd   = '{en: 1'b1, we: 1'b1};
              mem_wdata = '0;
            end
          end
          default: begin
          end
        endcase
      end
      S_W2: begin
        // mem_rdata holds the second-level descriptor
        state_next = S_DONE;
        if (mem_rdata[1:0] == DT_FAULT) begin
          res_next.status = ST_FAULT;
        end else if (req.req_type == REQ_XLATE) begin
          unique case (mem_rdata[1:0])
            PT_LARGE: res_next.xlate_addr = {mem_rdata[31:16], req.vaddr[15:0]};
            PT_SMALL: res_next.xlate_addr = {mem_rdata[31:12], req.vaddr[11:0]};
            PT_TINY:  res_next.xlate_addr = {mem_rdata[31:10], req.vaddr[9:0]};
            default:  res_next.status = ST_FAULT;
          endcase
        end else begin
          mem_cmd   = '{en: 1'b1, we: 1'b1};
          mem_addr  = slot;
          mem_wdata = (upd[1:0] == PT_SMALL) ? (upd | SMALL_AP_ALL) : upd;
          res_next.written_desc = mem_wdata;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      table_base <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        table_base <= cfg_data;
      end
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res  <= res_next;
    slot <= slot_next;
    if (in_take) begin
      req <= in_data;
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire
